[sv/triangle_sides_and_area_core_defines.svh]
// Assertion macros for the triangle sides and area core.
`ifndef TRIANGLE_SIDES_AND_AREA_CORE_DEFINES_SVH
`define TRIANGLE_SIDES_AND_AREA_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tsa assertion failed");
`define TSA_IMPLIES(lbl, ante, cons) `TSA_ASSERT(lbl, (ante) |-> (cons))
`else
`define TSA_ASSERT(lbl, prop)
`define TSA_IMPLIES(lbl, ante, cons)
`endif
`endif

[sv/tsa_pkg.sv]
// Shared constants and width helpers for the triangle sides and area core.
`default_nettype none
package tsa_pkg;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 8;
  localparam int AREA_W     = 31;

  function automatic int side_w(input int coord_bits, input int frac_bits);
    return coord_bits + 1 + frac_bits;
  endfunction
endpackage
`default_nettype wire

[sv/tsa_in_if.sv]
// Input channel: one triangle as three vertices.
`default_nettype none
interface tsa_in_if #(
  parameter int COORD_BITS = tsa_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;

  modport source (output valid, ax, ay, bx, by_coord, cx, cy, input ready);
  modport sink (input valid, ax, ay, bx, by_coord, cx, cy, output ready);
endinterface
`default_nettype wire

[sv/tsa_out_if.sv]
// Output channel: three side lengths and the area.
`default_nettype none
interface tsa_out_if #(
  parameter int COORD_BITS = tsa_pkg::COORD_BITS,
  parameter int FRAC_BITS  = tsa_pkg::FRAC_BITS
);
  localparam int SideW = tsa_pkg::side_w(COORD_BITS, FRAC_BITS);

  logic                      valid;
  logic                      ready;
  logic [SideW-1:0]          side_ab;
  logic [SideW-1:0]          side_bc;
  logic [SideW-1:0]          side_ca;
  logic [tsa_pkg::AREA_W-1:0] tri_area;

  modport source (output valid, side_ab, side_bc, side_ca, tri_area, input ready);
  modport sink (input valid, side_ab, side_bc, side_ca, tri_area, output ready);
endinterface
`default_nettype wire

[sv/tsa_isqrt_pipe.sv]
// Pipelined integer square root, one result bit per stage, with a tag.
`default_nettype none
module tsa_isqrt_pipe #(
  parameter int LANES = 1,
  parameter int IN_W  = 8,
  parameter int TAG_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic [IN_W-1:0]          rad_in   [LANES],
  input  logic [TAG_W-1:0]         tag_in,
  output logic [(IN_W+1)/2-1:0]    root_out [LANES],
  output logic [TAG_W-1:0]         tag_out
);
  localparam int RW = (IN_W + 1) / 2;
  localparam int NW = 2 * RW;

  logic [NW-1:0]    rad_r  [RW][LANES];
  logic [RW:0]      rem_r  [RW][LANES];
  logic [RW-1:0]    root_r [RW][LANES];
  logic [TAG_W-1:0] tag_r  [RW];

  for (genvar s = 0; s < RW; s++) begin : g_st
    logic [TAG_W-1:0] tag_p;
    if (s == 0) begin : g_tf
      assign tag_p = tag_in;
    end else begin : g_tn
      assign tag_p = tag_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_r[s] <= '0;
      end else if (en) begin
        tag_r[s] <= tag_p;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic [NW-1:0] rad_p;
      logic [RW:0]   rem_p;
      logic [RW-1:0] root_p;
      logic [RW+2:0] rem2;
      logic [RW+2:0] trial;
      logic          take;

      if (s == 0) begin : g_f
        assign rad_p  = NW'(rad_in[l]);
        assign rem_p  = '0;
        assign root_p = '0;
      end else begin : g_n
        assign rad_p  = rad_r[s-1][l];
        assign rem_p  = rem_r[s-1][l];
        assign root_p = root_r[s-1][l];
      end

      assign rem2  = {rem_p, rad_p[NW-1 -: 2]};
      assign trial = {1'b0, root_p, 2'b01};
      assign take  = rem2 >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          root_r[s][l] <= {root_p[RW-2:0], take};
          rem_r[s][l]  <= take ? (RW+1)'(rem2 - trial) : rem2[RW:0];
          rad_r[s][l]  <= {rad_p[NW-3:0], 2'b00};
        end
      end

      if (s == RW - 1) begin : g_o
        assign root_out[l] = root_r[s][l];
      end
    end
  end

  assign tag_out = tag_r[RW-1];
endmodule
`default_nettype wire

[sv/triangle_sides_and_area_core.sv]
// Top level: side lengths and Heron area of one triangle per transaction.
//
//   channel   dir   payload
//   in_ch     sink  ax ay bx by_coord cx cy (signed)
//   out_ch    src   side_ab side_bc side_ca tri_area
//
// One transaction per cycle while out_ch is not stalled; the pipeline depth is
// set mostly by the two bit-per-stage square root pipelines.
// rst clears all stage valid bits and the square root tag registers; other payload registers are not reset.
// A stall on out_ch freezes the whole pipeline; in_ch.ready drops with it.
`default_nettype none
`include "triangle_sides_and_area_core_defines.svh"
module triangle_sides_and_area_core #(
  parameter int COORD_BITS = tsa_pkg::COORD_BITS,
  parameter int FRAC_BITS  = tsa_pkg::FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  tsa_in_if.sink   in_ch,
  tsa_out_if.source out_ch
);
  localparam int C    = COORD_BITS;
  localparam int SW   = tsa_pkg::side_w(COORD_BITS, FRAC_BITS);
  localparam int D2W  = 2 * C + 1;
  localparam int RADW = D2W + 2 * FRAC_BITS;
  localparam int W01  = 2 * SW + 3;
  localparam int W23  = 2 * SW + 2;
  localparam int HL   = W23 / 2;
  localparam int HH   = W23 - HL;
  localparam int PW   = W01 + W23;
  localparam int ARW  = (PW + 1) / 2;
  localparam int AW   = tsa_pkg::AREA_W;

  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stages A and B: absolute coordinate differences, then squared distances
  logic [C-1:0] xs [3];
  logic [C-1:0] ys [3];
  assign xs[0] = in_ch.ax;
  assign xs[1] = in_ch.bx;
  assign xs[2] = in_ch.cx;
  assign ys[0] = in_ch.ay;
  assign ys[1] = in_ch.by_coord;
  assign ys[2] = in_ch.cy;

  logic         valid_a;
  logic [C-1:0] ux [3];
  logic [C-1:0] uy [3];
  logic [D2W-1:0] d2 [3];
  logic           valid_b;

  for (genvar l = 0; l < 3; l++) begin : g_d
    logic [C:0] dx, dy, ndx, ndy;
    assign dx  = {xs[l][C-1], xs[l]} - {xs[(l+1)%3][C-1], xs[(l+1)%3]};
    assign dy  = {ys[l][C-1], ys[l]} - {ys[(l+1)%3][C-1], ys[(l+1)%3]};
    assign ndx = -dx;
    assign ndy = -dy;
    always_ff @(posedge clk) begin
      if (en) begin
        ux[l] <= dx[C] ? ndx[C-1:0] : dx[C-1:0];
        uy[l] <= dy[C] ? ndy[C-1:0] : dy[C-1:0];
        d2[l] <= D2W'(ux[l] * ux[l]) + D2W'(uy[l] * uy[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else if (en) begin
      valid_a <= in_ch.valid;
      valid_b <= valid_a;
    end
  end

  // side square roots
  logic [RADW-1:0] rad_s  [3];
  logic [SW-1:0]   side_s [3];
  logic            valid_s;
  for (genvar l = 0; l < 3; l++) begin : g_r
    assign rad_s[l] = RADW'(d2[l]) << (2 * FRAC_BITS);
  end

  tsa_isqrt_pipe #(.LANES(3), .IN_W(RADW), .TAG_W(1)) u_side_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad_in   (rad_s),
    .tag_in   (valid_b),
    .root_out (side_s),
    .tag_out  (valid_s)
  );

  // stage T: Heron factors
  logic [SW+1:0] s1, s2, s3;
  assign s1 = (SW+2)'(side_s[1]) + (SW+2)'(side_s[2]) - (SW+2)'(side_s[0]);
  assign s2 = (SW+2)'(side_s[0]) - (SW+2)'(side_s[1]) + (SW+2)'(side_s[2]);
  assign s3 = (SW+2)'(side_s[0]) + (SW+2)'(side_s[1]) - (SW+2)'(side_s[2]);

  logic            valid_t, valid_m1, valid_m2, valid_m3;
  logic [3*SW-1:0] sides_t, sides_m1, sides_m2, sides_m3;
  logic [SW+1:0]   t0;
  logic [SW:0]     t1, t2, t3;
  logic            pos_t;
  logic [W01-1:0]  p01;
  logic [W23-1:0]  p23;
  logic [W01+HL-1:0] p_lo;
  logic [W01+HH-1:0] p_hi;
  logic [PW-1:0]   prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_t  <= 1'b0;
      valid_m1 <= 1'b0;
      valid_m2 <= 1'b0;
      valid_m3 <= 1'b0;
    end else if (en) begin
      valid_t  <= valid_s;
      valid_m1 <= valid_t;
      valid_m2 <= valid_m1;
      valid_m3 <= valid_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sides_t <= {side_s[0], side_s[1], side_s[2]};
      t0 <= (SW+2)'(side_s[0]) + (SW+2)'(side_s[1]) + (SW+2)'(side_s[2]);
      t1 <= s1[SW:0];
      t2 <= s2[SW:0];
      t3 <= s3[SW:0];
      pos_t <= !s1[SW+1] && (s1 != '0) && !s2[SW+1] && (s2 != '0)
               && !s3[SW+1] && (s3 != '0);
      // M1
      sides_m1 <= sides_t;
      p01 <= pos_t ? W01'(t0 * t1) : '0;
      p23 <= pos_t ? W23'(t2 * t3) : '0;
      // M2: split the wide product into two partial products
      sides_m2 <= sides_m1;
      p_lo <= (W01+HL)'(p01 * p23[HL-1:0]);
      p_hi <= (W01+HH)'(p01 * p23[W23-1:HL]);
      // M3
      sides_m3 <= sides_m2;
      prod <= PW'(p_lo) + (PW'(p_hi) << HL);
    end
  end

  // area square root
  logic [PW-1:0]        rad_a [1];
  logic [ARW-1:0]       root_a [1];
  logic [3*SW:0]        tag_a_out;
  assign rad_a[0] = prod;

  tsa_isqrt_pipe #(.LANES(1), .IN_W(PW), .TAG_W(3*SW+1)) u_area_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rad_in   (rad_a),
    .tag_in   ({valid_m3, sides_m3}),
    .root_out (root_a),
    .tag_out  (tag_a_out)
  );

  logic [ARW-1:0] area_sh;
  assign area_sh = root_a[0] >> (FRAC_BITS + 2);

  assign out_ch.valid    = tag_a_out[3*SW];
  assign out_ch.side_ab  = tag_a_out[3*SW-1 -: SW];
  assign out_ch.side_bc  = tag_a_out[2*SW-1 -: SW];
  assign out_ch.side_ca  = tag_a_out[SW-1:0];
  assign out_ch.tri_area = AW'(area_sh);

  logic [SW:0] sum_ab_bc, ext_ca;
  assign sum_ab_bc = (SW+1)'(out_ch.side_ab) + (SW+1)'(out_ch.side_bc);
  assign ext_ca    = (SW+1)'(out_ch.side_ca);

  `TSA_IMPLIES(a_zero_side, out_ch.valid && out_ch.side_ab == '0, out_ch.tri_area == '0)
  `TSA_IMPLIES(a_degenerate, out_ch.valid && sum_ab_bc <= ext_ca, out_ch.tri_area == '0)
  `TSA_IMPLIES(a_stall_ready, out_ch.valid && !out_ch.ready, !in_ch.ready)
endmodule
`default_nettype wire
